### hdl/led_matrix_row_refresh_serializer_core_macros.svh
// Assertion macros for the LED matrix row refresh serializer.
`ifndef LED_MATRIX_ROW_REFRESH_SERIALIZER_CORE_MACROS_SVH
`define LED_MATRIX_ROW_REFRESH_SERIALIZER_CORE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define LMRRS_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define LMRRS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lmrrs_pkg.sv
// Shared types and constants for the LED matrix row refresh serializer.
package lmrrs_pkg;

  localparam int CHIP_COUNT_DEF = 4;
  localparam int CHIP_MAX       = 4;
  localparam int CHIP_W         = $clog2(CHIP_MAX);
  localparam int ROW_W          = 3;
  localparam int STORE_DEPTH    = CHIP_MAX * (2 ** ROW_W);
  localparam int ADDR_W         = CHIP_W + ROW_W;
  localparam int BYTE_W         = 8;
  localparam int BIT_CNT_W      = 4;

  typedef enum logic [1:0] {
    OP_REFRESH = 2'd0,
    OP_WRITE   = 2'd1,
    OP_BCAST   = 2'd2
  } lmrrs_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } lmrrs_state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] frame_index;
    logic [7:0] byte_value;
    logic [3:0] cmd_address;
    logic [1:0] view_orientation;
  } lmrrs_in_t;

  typedef struct packed {
    logic serial_bit;
    logic frame_last;
  } lmrrs_out_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } lmrrs_mem_req_t;

endpackage

### hdl/lmrrs_frame_mem.sv
// Frame store: 32 x 8 memory with registered read and per-entry valid bits.
module lmrrs_frame_mem
  import lmrrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lmrrs_mem_req_t    mem_req,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0]      mem_r [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_r;
  logic [BYTE_W-1:0]      rd_data_r;

  // Write the array
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem_r[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  // Mark entries written since reset; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_req.wr_en) begin
      vld_r[mem_req.wr_addr] <= 1'b1;
    end
  end

  // Register read data; hold it between reads
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data_r <= vld_r[mem_req.rd_addr] ? mem_r[mem_req.rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/lmrrs_shifter.sv
// Sequencer: decodes items, scans rows, issues frame reads and writes and shifts out bits.
module lmrrs_shifter
  import lmrrs_pkg::*;
#(
  parameter int CHIP_COUNT = CHIP_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lmrrs_in_t         in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lmrrs_out_t        out_data,
  output lmrrs_mem_req_t    mem_req,
  input  logic [BYTE_W-1:0] rd_data
);

  localparam logic [CHIP_W-1:0] LAST_CHIP = CHIP_W'(CHIP_COUNT - 1);

  lmrrs_state_t         state_r,       state_nxt;
  logic [ROW_W-1:0]     scan_row_r,    scan_row_nxt;
  logic [1:0]           last_orient_r, last_orient_nxt;
  logic [ROW_W-1:0]     row_r,         row_nxt;
  logic [CHIP_W-1:0]    chip_r,        chip_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r,     bit_cnt_nxt;
  logic                 bcast_r,       bcast_nxt;
  logic [BYTE_W-1:0]    addr_byte_r,   addr_byte_nxt;
  logic [BYTE_W-1:0]    bdata_r,       bdata_nxt;
  logic                 out_valid_r,   out_valid_nxt;
  lmrrs_out_t           out_data_r,    out_data_nxt;
  logic [ROW_W-1:0]     row_sel;
  logic [BYTE_W-1:0]    cur_byte;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      scan_row_r    <= '0;
      last_orient_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      scan_row_r    <= scan_row_nxt;
      last_orient_r <= last_orient_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    chip_r      <= chip_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    bcast_r     <= bcast_nxt;
    addr_byte_r <= addr_byte_nxt;
    bdata_r     <= bdata_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Restart the scan on an orientation change
  assign row_sel = (in_data.view_orientation != last_orient_r) ? '0 : scan_row_r;

  // Byte being shifted: address byte first, then row or broadcast data
  assign cur_byte = bit_cnt_r[BIT_CNT_W-1] ? (bcast_r ? bdata_r : rd_data) : addr_byte_r;

  // Next state, memory requests and output word
  always_comb begin
    state_nxt       = state_r;
    scan_row_nxt    = scan_row_r;
    last_orient_nxt = last_orient_r;
    row_nxt         = row_r;
    chip_nxt        = chip_r;
    bit_cnt_nxt     = bit_cnt_r;
    bcast_nxt       = bcast_r;
    addr_byte_nxt   = addr_byte_r;
    bdata_nxt       = bdata_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;

    mem_req         = '0;
    mem_req.wr_addr = in_data.frame_index;
    mem_req.wr_data = in_data.byte_value;
    mem_req.rd_addr = {chip_r, row_r};

    // Drop the output word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.operation)
            OP_WRITE: begin
              mem_req.wr_en = 1'b1;
            end
            OP_REFRESH: begin
              last_orient_nxt = in_data.view_orientation;
              scan_row_nxt    = row_sel + 1'b1;
              row_nxt         = row_sel;
              chip_nxt        = '0;
              bit_cnt_nxt     = '0;
              bcast_nxt       = 1'b0;
              addr_byte_nxt   = BYTE_W'(row_sel) + 8'd1;
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = {{CHIP_W{1'b0}}, row_sel};
              state_nxt       = ST_SHIFT;
            end
            OP_BCAST: begin
              chip_nxt      = '0;
              bit_cnt_nxt   = '0;
              bcast_nxt     = 1'b1;
              addr_byte_nxt = {4'd0, in_data.cmd_address};
              bdata_nxt     = in_data.byte_value;
              state_nxt     = ST_SHIFT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        // Advance one bit when the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.serial_bit = cur_byte[3'd7 - bit_cnt_r[2:0]];
          out_data_nxt.frame_last = (bit_cnt_r == '1) && (chip_r == LAST_CHIP);
          bit_cnt_nxt             = bit_cnt_r + 1'b1;
          if (bit_cnt_r == '1) begin
            if (chip_r == LAST_CHIP) begin
              state_nxt = ST_IDLE;
            end else begin
              chip_nxt        = chip_r + 1'b1;
              mem_req.rd_en   = !bcast_r;
              mem_req.rd_addr = {chip_r + 1'b1, row_r};
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/led_matrix_row_refresh_serializer_core.sv
// Top level of the LED matrix row refresh serializer.
//
// Streams rows of a stored 32-byte frame to a daisy chain of CHIP_COUNT 8x8 LED
// matrix controllers, one serial bit per output word, MSB first, with frame_last
// set on the final bit (chip-select rise). A write word stores one frame byte. A
// refresh tick or broadcast shifts an address byte and a data byte to each chip
// in turn, and the input stays stalled until its last bit is shifted. Each chip's
// row byte is read from the frame memory (registered read) when the bit before
// its address byte is shifted, or when the refresh word is accepted for the first
// chip, so it is ready when the row byte begins to shift.
// The frame reads as all zeros after reset through per-entry valid bits, so no
// clearing pass is needed and words are taken from the first cycle after reset.
`include "led_matrix_row_refresh_serializer_core_macros.svh"

module led_matrix_row_refresh_serializer_core
  import lmrrs_pkg::*;
#(
  parameter int CHIP_COUNT = CHIP_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  lmrrs_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output lmrrs_out_t out_data
);

  lmrrs_mem_req_t    mem_req;
  logic [BYTE_W-1:0] rd_data;
  logic              in_take;
  logic              shift_start;

  lmrrs_shifter #(
    .CHIP_COUNT (CHIP_COUNT)
  ) u_shifter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  lmrrs_frame_mem u_frame_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // Decode accepted words for the checks below
  assign in_take     = in_valid && !in_stall;
  assign shift_start = in_take && (in_data.operation inside {OP_REFRESH, OP_BCAST});

  // A refresh or broadcast word keeps the input stalled while it shifts
  `LMRRS_ASSERT_NEXT(a_busy_after_start, shift_start, in_stall, "shift did not start")
  // A frame write completes in its accept cycle
  `LMRRS_ASSERT_NEXT(a_write_one_cycle, in_take && in_data.operation == OP_WRITE, !in_stall, "write held the input")
  // Hold a stalled output word
  `LMRRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled word changed")

endmodule
